/* rtl/tpds_pkg.sv */
// Shared types and constants for the touch-point decode and scale block.
package tpds_pkg;

    // Field widths fixed by the record format.
    localparam int RAW_W      = 12;
    localparam int POS_W      = 12;
    localparam int ID_W       = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Largest value an output coordinate can carry.
    localparam logic [POS_W-1:0] POS_MAX = 12'hFFF;

    // Event code that marks a finger in contact.
    localparam logic [1:0] EVT_CONTACT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_Y    = 3'd4;

    // Reset values of the limit registers.
    localparam logic [RAW_W-1:0] X_LIMIT_RST = 12'd540;
    localparam logic [RAW_W-1:0] Y_LIMIT_RST = 12'd960;

    // Configuration as seen by the front and back parts.
    typedef struct packed {
        logic [RAW_W-1:0] x_limit;
        logic [RAW_W-1:0] y_limit;
        logic             swap_axes;
        logic             flip_x;
        logic             flip_y;
    } cfg_t;

endpackage

/* rtl/tpds_front.sv */
// Front part: accepts raw records, unpacks and clamps them and forms the scaled dividends.
module tpds_front
    import tpds_pkg::*;
#(
    parameter int LOGICAL_MAX = 4095,
    parameter int ITEM_W      = 2 * (RAW_W + $clog2(LOGICAL_MAX + 1)) + 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        xh_byte,
    input  logic [7:0]        xl_byte,
    input  logic [7:0]        yh_byte,
    input  logic [7:0]        yl_byte,
    input  logic              final_in,
    input  logic              queue_full,
    output logic              push_valid,
    output logic [ITEM_W-1:0] push_data
);

    localparam int LM_W = $clog2(LOGICAL_MAX + 1);
    localparam int PW   = RAW_W + LM_W;

    logic             vld_reg;
    logic [PW-1:0]    prod_x_reg;
    logic [PW-1:0]    prod_y_reg;
    logic             contact_reg;
    logic [ID_W-1:0]  id_reg;
    logic             final_reg;

    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [RAW_W-1:0] clamp_x;
    logic [RAW_W-1:0] clamp_y;
    logic [PW-1:0]    prod_x_next;
    logic [PW-1:0]    prod_y_next;
    logic             load;

    // The held request moves on whenever the queue has room.
    assign in_stall   = vld_reg && queue_full;
    assign load       = !in_stall;
    assign push_valid = vld_reg && !queue_full;
    assign push_data  = {contact_reg, id_reg, final_reg, prod_x_reg, prod_y_reg};

    // Unpack the coordinates, clamp them to the limits and multiply by the logical range.
    always_comb
    begin
        raw_x       = {xh_byte[3:0], xl_byte};
        raw_y       = {yh_byte[3:0], yl_byte};
        clamp_x     = (raw_x > cfg.x_limit) ? cfg.x_limit : raw_x;
        clamp_y     = (raw_y > cfg.y_limit) ? cfg.y_limit : raw_y;
        prod_x_next = PW'(clamp_x) * PW'(LOGICAL_MAX);
        prod_y_next = PW'(clamp_y) * PW'(LOGICAL_MAX);
    end

    // Valid flag of the front register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= in_valid;
        end
    end

    // Payload of the front register.
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            prod_x_reg  <= prod_x_next;
            prod_y_reg  <= prod_y_next;
            contact_reg <= (xh_byte[7:6] == EVT_CONTACT);
            id_reg      <= yh_byte[7:4];
            final_reg   <= final_in;
        end
    end

endmodule

/* rtl/tpds_queue.sv */
// Short queue that decouples the front part from the divider pipeline.
module tpds_queue
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop_ready,
    output logic              pop_valid,
    output logic [DATA_W-1:0] pop_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [0:DEPTH-1];
    logic [AW-1:0]     wptr_reg;
    logic [AW-1:0]     rptr_reg;
    logic [CW-1:0]     cnt_reg;
    logic [AW-1:0]     wptr_next;
    logic [AW-1:0]     rptr_next;
    logic [CW-1:0]     cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = entry_reg[rptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_ready && pop_valid;

    // Pointer and fill count updates, wrapping at the depth.
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/tpds_back.sv */
// Back part: pipelined restoring dividers for both axes, then swap, mirror and saturate.
module tpds_back
    import tpds_pkg::*;
#(
    parameter int LOGICAL_MAX = 4095,
    parameter int ITEM_W      = 2 * (RAW_W + $clog2(LOGICAL_MAX + 1)) + 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              pop_valid,
    input  logic [ITEM_W-1:0] pop_data,
    output logic              pop_ready,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              contact,
    output logic [ID_W-1:0]   touch_id,
    output logic [POS_W-1:0]  pos_x,
    output logic [POS_W-1:0]  pos_y,
    output logic              final_out
);

    localparam int LM_W = $clog2(LOGICAL_MAX + 1);
    localparam int PW   = RAW_W + LM_W;
    localparam int QW   = LM_W;

    // One slot per divider step; slot QW holds finished quotients.
    logic [RAW_W-1:0] rx_reg [0:QW];
    logic [RAW_W-1:0] ry_reg [0:QW];
    logic [QW-1:0]    lx_reg [0:QW];
    logic [QW-1:0]    ly_reg [0:QW];
    logic [QW-1:0]    qx_reg [0:QW];
    logic [QW-1:0]    qy_reg [0:QW];
    logic             ct_reg [0:QW];
    logic [ID_W-1:0]  id_reg [0:QW];
    logic             fn_reg [0:QW];
    logic [QW:0]      vld_reg;

    logic             out_valid_reg;
    logic             contact_reg;
    logic [ID_W-1:0]  touch_id_reg;
    logic [POS_W-1:0] pos_x_reg;
    logic [POS_W-1:0] pos_y_reg;
    logic             final_reg;

    logic             advance;
    logic [PW-1:0]    in_px;
    logic [PW-1:0]    in_py;
    logic [LM_W-1:0]  sx;
    logic [LM_W-1:0]  sy;
    logic [LM_W-1:0]  ax;
    logic [LM_W-1:0]  ay;
    logic [LM_W-1:0]  fx;
    logic [LM_W-1:0]  fy;
    logic [31:0]      wx;
    logic [31:0]      wy;
    logic [POS_W-1:0] pos_x_next;
    logic [POS_W-1:0] pos_y_next;

    // The whole pipeline moves together whenever the output register can take a request.
    assign advance   = !out_valid_reg || !out_stall;
    assign pop_ready = advance;
    assign in_px     = pop_data[2*PW-1:PW];
    assign in_py     = pop_data[PW-1:0];

    // Valid bits of the divider slots.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[QW-1:0], pop_valid};
        end
    end

    // First slot: the upper product bits form the starting remainder.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rx_reg[0] <= in_px[PW-1:QW];
            ry_reg[0] <= in_py[PW-1:QW];
            lx_reg[0] <= in_px[QW-1:0];
            ly_reg[0] <= in_py[QW-1:0];
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            ct_reg[0] <= pop_data[2*PW+5];
            id_reg[0] <= pop_data[2*PW+4:2*PW+1];
            fn_reg[0] <= pop_data[2*PW];
        end
    end

    // One quotient bit per slot for each axis.
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int B = QW - 1 - k;
        logic [RAW_W:0]   tx;
        logic [RAW_W:0]   ty;
        logic [RAW_W:0]   dx;
        logic [RAW_W:0]   dy;
        logic             gx;
        logic             gy;
        logic [RAW_W-1:0] rx_next;
        logic [RAW_W-1:0] ry_next;
        logic [QW-1:0]    qx_next;
        logic [QW-1:0]    qy_next;

        always_comb
        begin
            tx      = {rx_reg[k], lx_reg[k][B]};
            ty      = {ry_reg[k], ly_reg[k][B]};
            gx      = (tx >= {1'b0, cfg.x_limit});
            gy      = (ty >= {1'b0, cfg.y_limit});
            dx      = tx - {1'b0, cfg.x_limit};
            dy      = ty - {1'b0, cfg.y_limit};
            rx_next = gx ? dx[RAW_W-1:0] : tx[RAW_W-1:0];
            ry_next = gy ? dy[RAW_W-1:0] : ty[RAW_W-1:0];
            qx_next    = qx_reg[k];
            qy_next    = qy_reg[k];
            qx_next[B] = gx;
            qy_next[B] = gy;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rx_reg[k+1] <= rx_next;
                ry_reg[k+1] <= ry_next;
                lx_reg[k+1] <= lx_reg[k];
                ly_reg[k+1] <= ly_reg[k];
                qx_reg[k+1] <= qx_next;
                qy_reg[k+1] <= qy_next;
                ct_reg[k+1] <= ct_reg[k];
                id_reg[k+1] <= id_reg[k];
                fn_reg[k+1] <= fn_reg[k];
            end
        end
    end

    // A zero limit gives zero, then swap, mirror and saturate to the output width.
    always_comb
    begin
        sx = (cfg.x_limit == '0) ? '0 : qx_reg[QW];
        sy = (cfg.y_limit == '0) ? '0 : qy_reg[QW];
        ax = cfg.swap_axes ? sy : sx;
        ay = cfg.swap_axes ? sx : sy;
        fx = cfg.flip_x ? LM_W'(LOGICAL_MAX) - ax : ax;
        fy = cfg.flip_y ? LM_W'(LOGICAL_MAX) - ay : ay;
        wx = 32'(fx);
        wy = 32'(fy);
        pos_x_next = (wx > 32'(POS_MAX)) ? POS_MAX : wx[POS_W-1:0];
        pos_y_next = (wy > 32'(POS_MAX)) ? POS_MAX : wy[POS_W-1:0];
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= vld_reg[QW];
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            contact_reg  <= ct_reg[QW];
            touch_id_reg <= id_reg[QW];
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            final_reg    <= fn_reg[QW];
        end
    end

    assign out_valid = out_valid_reg;
    assign contact   = contact_reg;
    assign touch_id  = touch_id_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign final_out = final_reg;

endmodule

/* rtl/touch_point_decode_scale_unit.sv */
// Top level of the touch-point decoder and scaler: configuration registers and part wiring.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    xh_byte, xl_byte, yh_byte, yl_byte, final_in
//   output    out_valid / out_stall  contact, touch_id, pos_x, pos_y, final_out
//   config    cfg_we                 cfg_index, cfg_data
//
// One request is accepted per cycle while in_stall is low; a request passes through the front
// register, the queue, the divider steps (one per bit of LOGICAL_MAX) and the output register.
// rst_n is asynchronous; it clears valid flags and queue pointers and reloads config defaults.
// A stalled output holds the divider pipeline; the front keeps accepting until the
// four-entry queue fills, then raises in_stall.
module touch_point_decode_scale_unit
    import tpds_pkg::*;
#(
    parameter int LOGICAL_MAX = 4095
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            xh_byte,
    input  logic [7:0]            xl_byte,
    input  logic [7:0]            yh_byte,
    input  logic [7:0]            yl_byte,
    input  logic                  final_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  contact,
    output logic [ID_W-1:0]       touch_id,
    output logic [POS_W-1:0]      pos_x,
    output logic [POS_W-1:0]      pos_y,
    output logic                  final_out
);

    localparam int LM_W   = $clog2(LOGICAL_MAX + 1);
    localparam int ITEM_W = 2 * (RAW_W + LM_W) + 6;

    cfg_t              cfg_reg;
    logic              push_valid;
    logic [ITEM_W-1:0] push_data;
    logic              queue_full;
    logic              pop_ready;
    logic              pop_valid;
    logic [ITEM_W-1:0] pop_data;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_limit   <= X_LIMIT_RST;
            cfg_reg.y_limit   <= Y_LIMIT_RST;
            cfg_reg.swap_axes <= 1'b0;
            cfg_reg.flip_x    <= 1'b0;
            cfg_reg.flip_y    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_X_LIMIT:   cfg_reg.x_limit   <= cfg_data[RAW_W-1:0];
                CFG_Y_LIMIT:   cfg_reg.y_limit   <= cfg_data[RAW_W-1:0];
                CFG_SWAP_AXES: cfg_reg.swap_axes <= cfg_data[0];
                CFG_FLIP_X:    cfg_reg.flip_x    <= cfg_data[0];
                CFG_FLIP_Y:    cfg_reg.flip_y    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Front part: decode, clamp and multiply.
    tpds_front #(
        .LOGICAL_MAX (LOGICAL_MAX),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .xh_byte    (xh_byte),
        .xl_byte    (xl_byte),
        .yh_byte    (yh_byte),
        .yl_byte    (yl_byte),
        .final_in   (final_in),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // Queue between the two parts.
    tpds_queue #(
        .DATA_W (ITEM_W),
        .DEPTH  (4)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop_ready  (pop_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    // Back part: divide, swap, mirror and saturate.
    tpds_back #(
        .LOGICAL_MAX (LOGICAL_MAX),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .contact   (contact),
        .touch_id  (touch_id),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .final_out (final_out)
    );

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the touch-point decoder and scaler: corner and random records with a predictor.
module tb_top;
    import tpds_pkg::*;

    localparam int LOG_MAX        = 4095;
    localparam int HOLD_OFF       = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_WAIT       = 13;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 100;

    // One raw touch record as it enters the block.
    typedef struct packed {
        logic [7:0] xh;
        logic [7:0] xl;
        logic [7:0] yh;
        logic [7:0] yl;
        logic       fin;
    } touch_rec_t;

    // One decoded point as it leaves the block.
    typedef struct packed {
        logic             contact;
        logic [ID_W-1:0]  touch_id;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             last_flag;
    } point_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            xh_byte;
    logic [7:0]            xl_byte;
    logic [7:0]            yh_byte;
    logic [7:0]            yl_byte;
    logic                  final_in;
    logic                  out_valid;
    logic                  out_stall;
    logic                  contact;
    logic [ID_W-1:0]       touch_id;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic                  final_out;

    // Shadow of the configuration registers and the points still to come.
    cfg_t   cur_cfg;
    point_t expected_points[$];
    int     mismatch_count = 0;
    int     stall_left     = 0;
    int     idle_cycles    = 0;
    bit     quiet          = 1'b0;

    touch_point_decode_scale_unit #(
        .LOGICAL_MAX (LOG_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .xh_byte   (xh_byte),
        .xl_byte   (xl_byte),
        .yh_byte   (yh_byte),
        .yl_byte   (yl_byte),
        .final_in  (final_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .contact   (contact),
        .touch_id  (touch_id),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .final_out (final_out)
    );

    // Free-running clock with a period of two time units.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Clamp one raw coordinate to its limit and scale it to the logical range.
    function automatic logic [31:0] scale_axis(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] limit);
        logic [31:0] clamped;
        if (limit == '0)
        begin
            return '0;
        end
        clamped = (raw > limit) ? limit : raw;
        return (clamped * LOG_MAX) / limit;
    endfunction

    // Work out the point that the block should return for one record.
    function automatic point_t decode_point(touch_rec_t r);
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] swap_tmp;
        point_t      p;
        sx = scale_axis({r.xh[3:0], r.xl}, cur_cfg.x_limit);
        sy = scale_axis({r.yh[3:0], r.yl}, cur_cfg.y_limit);
        if (cur_cfg.swap_axes)
        begin
            swap_tmp = sx;
            sx       = sy;
            sy       = swap_tmp;
        end
        if (cur_cfg.flip_x)
        begin
            sx = LOG_MAX - sx;
        end
        if (cur_cfg.flip_y)
        begin
            sy = LOG_MAX - sy;
        end
        p.contact   = (r.xh[7:6] == EVT_CONTACT);
        p.touch_id  = r.yh[7:4];
        p.pos_x     = (sx > POS_MAX) ? POS_MAX : sx[POS_W-1:0];
        p.pos_y     = (sy > POS_MAX) ? POS_MAX : sy[POS_W-1:0];
        p.last_flag = r.fin;
        return p;
    endfunction

    // Limits lean toward the edges: zero, one, full scale and small values.
    function automatic logic [RAW_W-1:0] random_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return RAW_W'(1);
            2:       return '1;
            3:       return RAW_W'($urandom_range(1, 64));
            default: return RAW_W'($urandom_range(1, 4095));
        endcase
    endfunction

    function automatic cfg_t random_setup();
        cfg_t c;
        c.x_limit   = random_limit();
        c.y_limit   = random_limit();
        c.swap_axes = 1'($urandom);
        c.flip_x    = 1'($urandom);
        c.flip_y    = 1'($urandom);
        return c;
    endfunction

    // A random record; a quarter of the coordinates sit at the limit or one away from it.
    function automatic touch_rec_t random_record();
        logic [RAW_W-1:0] rx;
        logic [RAW_W-1:0] ry;
        logic [31:0]      bits;
        touch_rec_t       r;
        rx   = RAW_W'($urandom);
        ry   = RAW_W'($urandom);
        bits = $urandom;
        if ($urandom_range(0, 3) == 0)
        begin
            rx = cur_cfg.x_limit + RAW_W'($urandom_range(0, 2)) - RAW_W'(1);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            ry = cur_cfg.y_limit + RAW_W'($urandom_range(0, 2)) - RAW_W'(1);
        end
        r.xh  = {bits[7:4], rx[11:8]};
        r.xl  = rx[7:0];
        r.yh  = {bits[11:8], ry[11:8]};
        r.yl  = ry[7:0];
        r.fin = bits[12];
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Send one request after a random gap (none when quiet) and record the point it must produce.
    // Returns at the falling edge after acceptance with in_valid still high.
    task automatic send_record(touch_rec_t r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        xh_byte  <= r.xh;
        xl_byte  <= r.xl;
        yh_byte  <= r.yh;
        yl_byte  <= r.yl;
        final_in <= r.fin;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        expected_points.push_back(decode_point(r));
        @(negedge clk);
    endtask

    // Stop sending and wait until every outstanding point has come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (HOLD_OFF) @(negedge clk);
    endtask

    // Write all registers, preceded by a write to an unused index that must be ignored.
    // Flag registers get random upper data bits; only bit 0 counts.
    task automatic apply_setup(cfg_t c);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx[0] = CFG_IDX_W'(CFG_FLIP_Y + 1 + $urandom_range(0, 2));
        val[0] = CFG_DATA_W'($urandom);
        idx[1] = CFG_X_LIMIT;
        val[1] = c.x_limit;
        idx[2] = CFG_Y_LIMIT;
        val[2] = c.y_limit;
        idx[3] = CFG_SWAP_AXES;
        val[3] = {11'($urandom), c.swap_axes};
        idx[4] = CFG_FLIP_X;
        val[4] = {11'($urandom), c.flip_x};
        idx[5] = CFG_FLIP_Y;
        val[5] = {11'($urandom), c.flip_y};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(negedge clk);
        end
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    // Corner records: all zeros, all ones, contact with ignored bits set,
    // coordinates at and just past the reset limits, and the largest touch id.
    task automatic send_corners(int count);
        touch_rec_t corners [8];
        corners[0] = '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
        corners[1] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1};
        corners[2] = '{8'h80, 8'h00, 8'hF0, 8'h00, 1'b1};
        corners[3] = '{8'hBF, 8'hFF, 8'h0F, 8'hFF, 1'b0};
        corners[4] = '{8'h82, 8'h1C, 8'h03, 8'hC0, 1'b0};
        corners[5] = '{8'h42, 8'h1D, 8'h13, 8'hC1, 1'b1};
        corners[6] = '{8'h30, 8'h01, 8'h50, 8'h01, 1'b0};
        corners[7] = '{8'hA0, 8'h01, 8'hA0, 8'h01, 1'b1};
        for (int i = 0; i < count; i++)
        begin
            send_record(corners[i]);
        end
    endtask

    task automatic test_reset_defaults();
        send_corners(8);
        wait_drain();
    endtask

    // Zero, one and full-scale limits under swap and each mirroring.
    task automatic test_axis_setups();
        cfg_t setups [3];
        setups[0] = '{12'd0,    12'd4095, 1'b1, 1'b1, 1'b1};
        setups[1] = '{12'd1,    12'd1,    1'b0, 1'b1, 1'b0};
        setups[2] = '{12'd4095, 12'd0,    1'b1, 1'b0, 1'b1};
        for (int i = 0; i < 3; i++)
        begin
            apply_setup(setups[i]);
            send_corners(4);
            wait_drain();
        end
    endtask

    // Random setups, each with a phase of random records; some phases run without gaps.
    task automatic test_random_phases();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            apply_setup(random_setup());
            quiet = (phase == 1) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_record(random_record());
                if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1)
                begin
                    wait_drain();
                end
            end
            wait_drain();
        end
        quiet = 1'b0;
    endtask

    // Compare each accepted result with the oldest outstanding point.
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                check_field("contact", want.contact, contact);
                check_field("touch_id", want.touch_id, touch_id);
                check_field("pos_x", want.pos_x, pos_x);
                check_field("pos_y", want.pos_y, pos_y);
                check_field("final_out", want.last_flag, final_out);
            end
            stall_left = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        end
    end

    // Hold off the output for a random number of cycles after each result.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // End the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        xh_byte   = '0;
        xl_byte   = '0;
        yh_byte   = '0;
        yl_byte   = '0;
        final_in  = 1'b0;
        out_stall = 1'b0;
        cur_cfg   = '{X_LIMIT_RST, Y_LIMIT_RST, 1'b0, 1'b0, 1'b0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_axis_setups();
        test_random_phases();

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
